FILE: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

   // Queue size and the widths that follow from it.
   localparam int Q_DEPTH = 8;
   localparam int CNT_W   = $clog2(Q_DEPTH + 1);
   localparam int ADDR_W  = $clog2(Q_DEPTH);
   localparam int VAL_W   = 32;
   localparam int OCC_W   = 4;

   // Request codes carried on the request tuser.
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   // Result status codes carried on the response tuser.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Outcome of the shared compare unit.
   typedef struct packed {
      logic ge;
      logic eq;
   } cmp_res_type;

endpackage

`default_nettype wire

FILE: rtl/core/spq_ram.sv
`default_nettype none

module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/spq_cmp.sv
`default_nettype none

module spq_cmp
   import spq_pkg::*;
(
   input  wire logic signed [VAL_W-1:0] a,
   input  wire logic signed [VAL_W-1:0] b,
   output cmp_res_type                  res
);

   // Signed two's complement order and equality compare of the request value against one entry.
   always_comb begin
      res.ge = (a >= b);
      res.eq = (a == b);
   end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
`default_nettype none

// Channel   Ports                 Word contents (lowest bit first)
// request   req_tvalid/tready     tdata: value[31:0]; tuser: req_type[1:0]
// response  rsp_tvalid/tready     tdata: data_out[31:0], occupancy[35:32], zero[39:36];
//                                 tuser: status[1:0]; tlast: is_last
//
// One request is in work at a time; req_tready is high only while the sequencer is idle.
// Insert moves entries down from the tail until it reaches a larger entry or the head; delete
// scans from the head for an equal entry and then moves each later entry up one place.
// Each step reads an entry first,
// because the single entry memory registers its read data.
// A read-out emits one word per entry, each loaded once the response register is free.
// Reset clears the state, count and response valid flag; the entry memory is not cleared.
// A stalled response holds in its register; the next request can still be taken.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // value[31:0]
   input  wire logic [1:0]  req_tuser,  // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // data_out[31:0], occupancy[35:32], zero[39:36]
   output logic [1:0]       rsp_tuser,  // status[1:0]
   output logic             rsp_tlast   // is_last
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_INS_RD   = 10'b00_0000_0010,
      S_INS_CMP  = 10'b00_0000_0100,
      S_DEL_RD   = 10'b00_0000_1000,
      S_DEL_CMP  = 10'b00_0001_0000,
      S_SHF_RD   = 10'b00_0010_0000,
      S_SHF_WR   = 10'b00_0100_0000,
      S_OUT_RD   = 10'b00_1000_0000,
      S_OUT_WAIT = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [VAL_W-1:0]       val_ff, val_in;
   status_type             status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;
   logic                   rsp_last_ff, rsp_last_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [VAL_W-1:0]       ram_wdata;
   logic                   ram_re;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [VAL_W-1:0]       ram_rdata;
   cmp_res_type            cmp_res;

   logic                   req_accept;
   logic                   out_free;
   req_code_type           req_code;
   logic [CNT_W-1:0]       idx_dec;
   logic [CNT_W-1:0]       idx_inc;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_code   = req_code_type'(req_tuser);
   assign idx_dec    = idx_ff - CNT_W'(1);
   assign idx_inc    = idx_ff + CNT_W'(1);

   // Entry store and the shared compare unit.
   spq_ram #(
      .WIDTH (VAL_W),
      .DEPTH (Q_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   spq_cmp u_cmp (
      .a   (val_ff),
      .b   (ram_rdata),
      .res (cmp_res)
   );

   // Sequencer: walks the entries one step at a time through the memory port.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[ADDR_W-1:0];
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               val_in = req_tdata;
               unique case (req_code)
                  REQ_INSERT: begin
                     if (count_ff >= CNT_W'(Q_DEPTH)) begin
                        status_in = ST_OVERFLOW;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  REQ_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DEL_RD;
                     end
                  end
                  REQ_READ: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = '0;
                        state_in = S_OUT_RD;
                     end
                  end
                  default: begin
                     // Unused code: dropped without a result.
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Insert: move smaller-or-equal entries down from the tail.
         S_INS_RD: begin
            if (idx_ff == '0) begin
               ram_we    = 1'b1;
               ram_wdata = val_ff;
               count_in  = count_ff + CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_dec[ADDR_W-1:0];
               state_in  = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            ram_we = 1'b1;
            if (cmp_res.ge) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_dec;
               state_in  = S_INS_RD;
            end else begin
               ram_wdata = val_ff;
               count_in  = count_ff + CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end

         // Delete: scan from the head for the first equal entry.
         S_DEL_RD: begin
            if (idx_ff == count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_DEL_CMP;
            end
         end

         S_DEL_CMP: begin
            if (cmp_res.eq) begin
               state_in = S_SHF_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_DEL_RD;
            end
         end

         // Close the gap by moving later entries up one place.
         S_SHF_RD: begin
            if (idx_inc == count_ff) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_inc[ADDR_W-1:0];
               state_in  = S_SHF_WR;
            end
         end

         S_SHF_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_inc;
            state_in  = S_SHF_RD;
         end

         // Read-out: one entry per response word, highest first.
         S_OUT_RD: begin
            ram_re   = 1'b1;
            state_in = S_OUT_WAIT;
         end

         S_OUT_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = ram_rdata;
               rsp_occ_in    = OCC_W'(count_ff);
               rsp_last_in   = (idx_inc == count_ff);
               rsp_status_in = ST_OK;
               if (idx_inc == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_OUT_RD;
               end
            end
         end

         // Single status word that ends insert, delete and empty read-out.
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_occ_in    = OCC_W'(count_ff);
               rsp_last_in   = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_occ_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The stored count never exceeds the queue size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(Q_DEPTH))
      else $error("entry count above queue size");

   // The memory is never written while no request is in work.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("entry write while idle");

   // The work index never exceeds the entry count.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (idx_ff <= count_ff))
      else $error("work index beyond count");

   // The count moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((count_ff == $past(count_ff)) ||
                (count_ff == $past(count_ff) + CNT_W'(1)) ||
                (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("count jumped");

   // A new response word is loaded only when the register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

FILE: dv/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   // Request code that the block must ignore without a response.
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         LIMIT_CYCLES = 200000;
   localparam int         RANDOM_ITEMS = 100;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 60;

   // One response word as the queue should produce it.
   typedef struct {
      status_type  status;
      logic [31:0] data;
      logic        last;
      logic [3:0]  occ;
   } rsp_word_type;

   // Scoreboard: keeps its own sorted copy of the queue and the words still due.
   class queue_scoreboard;
      logic signed [31:0] sorted_slots[$];
      rsp_word_type       expected_words[$];
      int                 errors;
      int                 words_checked;
      int                 req_count[4];
      int                 status_count[4];

      function void push_word(status_type st, logic [31:0] d, logic l);
         rsp_word_type w;
         w.status = st;
         w.data   = d;
         w.last   = l;
         w.occ    = 4'(sorted_slots.size());
         expected_words.push_back(w);
         status_count[st]++;
      endfunction

      // Apply one accepted request to the local queue and note the words it causes.
      function void note_request(logic [1:0] code, logic signed [31:0] val);
         int pos;
         req_count[code]++;
         case (code)
            REQ_INSERT: begin
               if (sorted_slots.size() >= Q_DEPTH) begin
                  push_word(ST_OVERFLOW, '0, 1'b1);
               end else begin
                  // A new value goes ahead of the first entry it is not below.
                  pos = 0;
                  while (pos < sorted_slots.size() && val < sorted_slots[pos]) pos++;
                  sorted_slots.insert(pos, val);
                  push_word(ST_OK, '0, 1'b1);
               end
            end
            REQ_DELETE: begin
               if (sorted_slots.size() == 0) begin
                  push_word(ST_EMPTY, '0, 1'b1);
               end else begin
                  pos = 0;
                  while (pos < sorted_slots.size() && sorted_slots[pos] != val) pos++;
                  if (pos == sorted_slots.size()) begin
                     push_word(ST_NOT_FOUND, '0, 1'b1);
                  end else begin
                     sorted_slots.delete(pos);
                     push_word(ST_OK, '0, 1'b1);
                  end
               end
            end
            REQ_READ: begin
               if (sorted_slots.size() == 0) begin
                  push_word(ST_EMPTY, '0, 1'b1);
               end else begin
                  foreach (sorted_slots[i])
                     push_word(ST_OK, sorted_slots[i], i == sorted_slots.size() - 1);
               end
            end
            default: begin
               // The unused code is dropped by the block.
            end
         endcase
      endfunction

      function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
         errors++;
         $display("%0t: response %s mismatch, expected %h actual %h", $time, field,
                  exp_v, act_v);
      endfunction

      // Compare one accepted response word with the oldest one due.
      function void check_word(logic [1:0] st, logic [31:0] d, logic l, logic [3:0] occ,
                               logic [3:0] pad);
         rsp_word_type w;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word, expected none actual status %0d data %h",
                     $time, st, d);
            return;
         end
         w = expected_words.pop_front();
         words_checked++;
         if (st !== w.status) report("status", w.status, st);
         if (d !== w.data) report("data", w.data, d);
         if (l !== w.last) report("last", w.last, l);
         if (occ !== w.occ) report("occupancy", w.occ, occ);
         if (pad !== 4'd0) report("pad", 4'd0, pad);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   queue_scoreboard sb;
   bit              calm = 1'b0;
   bit              hold_off_req = 1'b0;
   int              long_holds = 0;
   int              cycle_count = 0;

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle count for the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == LIMIT_CYCLES);
      $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one request word and wait until it is taken.
   task automatic send_req(input logic [1:0] code, input logic [31:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= code;
      do @(posedge clock); while (!req_tready);
      sb.note_request(code, val);
   endtask

   // Response side: check each accepted word, then pick the next ready level.
   initial begin
      int stall_left;
      stall_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tuser, rsp_tdata[31:0], rsp_tlast, rsp_tdata[35:32],
                          rsp_tdata[39:36]);
         if (hold_off_req) begin
            // Long hold-off so that the block fills up and stalls its input.
            stall_left   = HOLD_CYCLES;
            hold_off_req = 1'b0;
            long_holds++;
         end
         if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Request side: directed words first, then random sequences.
   initial begin
      logic [31:0] pool[6];
      logic [31:0] val;
      int          roll;
      int          ins_w;
      int          del_w;
      int          sent;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty queue cases.
      send_req(REQ_READ, 32'h0);
      send_req(REQ_DELETE, 32'd5);
      // Fill with the extremes and equal values, then overflow.
      send_req(REQ_INSERT, 32'h0);
      send_req(REQ_INSERT, 32'h7fff_ffff);
      send_req(REQ_INSERT, 32'h8000_0000);
      send_req(REQ_INSERT, 32'hffff_ffff);
      send_req(REQ_INSERT, 32'h0);
      send_req(REQ_INSERT, 32'd100);
      send_req(REQ_INSERT, -32'sd100);
      send_req(REQ_INSERT, 32'h0);
      send_req(REQ_INSERT, 32'd7);
      send_req(REQ_READ, 32'h0);
      send_req(REQ_UNUSED, 32'hffff_ffff);
      // Deletes: absent value, first of duplicates, both extremes.
      send_req(REQ_DELETE, 32'd55);
      send_req(REQ_DELETE, 32'h0);
      send_req(REQ_DELETE, 32'h7fff_ffff);
      send_req(REQ_DELETE, 32'h8000_0000);
      send_req(REQ_READ, 32'h0);
      send_req(REQ_DELETE, 32'hffff_ffff);
      send_req(REQ_DELETE, 32'd100);
      send_req(REQ_DELETE, -32'sd100);
      send_req(REQ_DELETE, 32'h0);
      send_req(REQ_DELETE, 32'h0);
      send_req(REQ_READ, 32'h0);

      // A small pool of values makes duplicates and successful deletes common.
      foreach (pool[i]) pool[i] = $urandom();
      hold_off_req = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm  = (sent >= 50 && sent < 70);
         ins_w = (sent < RANDOM_ITEMS / 2) ? 55 : 25;
         del_w = (sent < RANDOM_ITEMS / 2) ? 25 : 55;
         roll  = $urandom_range(0, 99);
         if (roll < ins_w) begin
            val = ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
            send_req(REQ_INSERT, val);
            sent++;
         end else if (roll < ins_w + del_w) begin
            if (sb.sorted_slots.size() > 0 && $urandom_range(0, 3) != 0)
               val = sb.sorted_slots[$urandom_range(0, sb.sorted_slots.size() - 1)];
            else
               val = $urandom();
            send_req(REQ_DELETE, val);
            sent++;
         end else if (roll < 95) begin
            send_req(REQ_READ, $urandom());
            sent++;
         end else begin
            send_req(REQ_UNUSED, $urandom());
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // Wait for every word still due, then watch for strays.
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d deletes, %0d read-outs and %0d ignored codes.",
               sb.req_count[REQ_INSERT], sb.req_count[REQ_DELETE], sb.req_count[REQ_READ],
               sb.req_count[REQ_UNUSED]);
      $display("Checked %0d words: %0d overflow, %0d empty, %0d not found, %0d long holds.",
               sb.words_checked, sb.status_count[ST_OVERFLOW], sb.status_count[ST_EMPTY],
               sb.status_count[ST_NOT_FOUND], long_holds);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
